FILE: rtl/core/bphd_pkg.sv
// Package: item types, opcodes, event codes and register defaults for the button detector.
`timescale 1ns / 1ps

package bphd_pkg;

  // Default sizing
  localparam int unsigned ButtonsDefault = 4;
  localparam int unsigned ReadsDefault   = 4;

  // Fixed field widths
  localparam int unsigned OpW     = 3;
  localparam int unsigned RawW    = 16;
  localparam int unsigned IdxW    = 3;
  localparam int unsigned EvW     = 3;
  localparam int unsigned CntW    = 8;
  localparam int unsigned MaskW   = 4;
  localparam int unsigned CodesW  = 12;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned CfgDatW = 8;

  // Opcodes
  localparam logic [OpW-1:0] OP_TICK          = 3'd0;
  localparam logic [OpW-1:0] OP_PEEK_PRESSED  = 3'd1;
  localparam logic [OpW-1:0] OP_TAKE_PRESSED  = 3'd2;
  localparam logic [OpW-1:0] OP_TAKE_HOLD     = 3'd3;
  localparam logic [OpW-1:0] OP_PEEK_RELEASED = 3'd4;
  localparam logic [OpW-1:0] OP_TAKE_RELEASED = 3'd5;
  localparam logic [OpW-1:0] OP_TAKE_HOLD_REL = 3'd6;

  // Event codes
  localparam logic [EvW-1:0] EV_NONE          = 3'd0;
  localparam logic [EvW-1:0] EV_PRESSED       = 3'd1;
  localparam logic [EvW-1:0] EV_RELEASED      = 3'd2;
  localparam logic [EvW-1:0] EV_HOLD          = 3'd3;
  localparam logic [EvW-1:0] EV_HOLD_RELEASED = 3'd4;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CFG_HOLD_TICKS     = 4'd0;
  localparam logic [CfgIdxW-1:0] CFG_SHUTDOWN_TICKS = 4'd1;
  localparam logic [CfgIdxW-1:0] CFG_AP_MODE_TICKS  = 4'd2;
  localparam logic [CfgIdxW-1:0] CFG_BATTERY_MODE   = 4'd3;

  // Register reset values
  localparam logic [CntW-1:0] HoldTicksRst     = 8'd15;
  localparam logic [CntW-1:0] ShutdownTicksRst = 8'd60;
  localparam logic [CntW-1:0] ApModeTicksRst   = 8'd20;

  localparam logic [CntW-1:0] CntMax = 8'd255;

  typedef struct packed {
    logic [OpW-1:0]  opcode;
    logic [RawW-1:0] raw_reads;
    logic [IdxW-1:0] button_index;
    logic            external_power;
  } in_item_t;

  typedef struct packed {
    logic              query_true;
    logic [MaskW-1:0]  pressed_mask;
    logic [CodesW-1:0] event_codes;
    logic              wake_scan;
    logic              shutdown_request;
    logic              ap_mode_request;
  } out_item_t;

  // Per-button control from the top level
  typedef struct packed {
    logic tick;
    logic down;
    logic clr;
  } btn_ctl_t;

endpackage

FILE: rtl/core/bphd_button.sv
// One button: down flag, saturating hold counter, pending and last event.
`timescale 1ns / 1ps

module bphd_button
  import bphd_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  btn_ctl_t        ctl_i,
  input  logic [CntW-1:0] hold_ticks_i,
  output logic [EvW-1:0]  pend_q_o,
  output logic            down_d_o,
  output logic [CntW-1:0] hold_d_o,
  output logic [EvW-1:0]  pend_d_o
);

  logic            down_q, down_d;
  logic [CntW-1:0] hold_q, hold_d;
  logic [EvW-1:0]  pend_q, pend_d;
  logic [EvW-1:0]  last_q, last_d;

  // Next state for a tick or a take
  always_comb begin
    down_d = down_q;
    hold_d = hold_q;
    pend_d = pend_q;
    last_d = last_q;
    if (ctl_i.tick) begin
      if (ctl_i.down) begin
        if (!down_q) begin
          pend_d = EV_PRESSED;
          last_d = EV_PRESSED;
        end
        down_d = 1'b1;
        if (hold_q != CntMax) begin
          hold_d = hold_q + 1'b1;
          if (hold_d >= hold_ticks_i && last_d != EV_HOLD) begin
            pend_d = EV_HOLD;
            last_d = EV_HOLD;
          end
        end
      end else begin
        if (down_q) begin
          if (last_q == EV_HOLD) begin
            pend_d = EV_HOLD_RELEASED;
            last_d = EV_HOLD_RELEASED;
          end else if (last_q != EV_RELEASED) begin
            pend_d = EV_RELEASED;
            last_d = EV_RELEASED;
          end
        end
        down_d = 1'b0;
        hold_d = '0;
      end
    end else if (ctl_i.clr) begin
      pend_d = EV_NONE;
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      down_q <= 1'b0;
      hold_q <= '0;
      pend_q <= EV_NONE;
      last_q <= EV_NONE;
    end else begin
      down_q <= down_d;
      hold_q <= hold_d;
      pend_q <= pend_d;
      last_q <= last_d;
    end
  end

  assign pend_q_o = pend_q;
  assign down_d_o = down_d;
  assign hold_d_o = hold_d;
  assign pend_d_o = pend_d;

endmodule

FILE: rtl/core/button_press_hold_event_detector_unit.sv
// Top level: config registers, per-button trackers, battery decision, result register.
//
//  channel | direction | handshake                  | payload
//  in      | input     | in_valid_i / in_ready_o    | in_item_i  (in_item_t)
//  out     | output    | out_valid_o / out_ready_i  | out_item_o (out_item_t)
//  cfg     | input     | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// One item per cycle unless the output stalls: the state update and the result are
// formed in the accept cycle, and the result appears from the result register in the
// following cycle; the unit has a single result register.
// in_ready_o is high while the result register is empty or being drained.
// Reset clears all button state, the shutdown latch and the registers to their defaults.
// cfg_ready_o is always high.
`timescale 1ns / 1ps

module button_press_hold_event_detector_unit
  import bphd_pkg::*;
#(
  parameter int unsigned BUTTONS = ButtonsDefault,
  parameter int unsigned READS   = ReadsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_item_t           in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_item_t          out_item_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgDatW-1:0] cfg_data_i
);

  // Config registers
  logic [CntW-1:0] hold_ticks_q, shutdown_ticks_q, ap_mode_ticks_q;
  logic            battery_mode_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_ticks_q     <= HoldTicksRst;
      shutdown_ticks_q <= ShutdownTicksRst;
      ap_mode_ticks_q  <= ApModeTicksRst;
      battery_mode_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_HOLD_TICKS:     hold_ticks_q     <= cfg_data_i;
        CFG_SHUTDOWN_TICKS: shutdown_ticks_q <= cfg_data_i;
        CFG_AP_MODE_TICKS:  ap_mode_ticks_q  <= cfg_data_i;
        CFG_BATTERY_MODE:   battery_mode_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Handshake
  logic out_valid_q;
  logic in_acc;
  logic is_tick;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;
  assign is_tick    = in_acc && (in_item_i.opcode == OP_TICK);

  // Query decode
  logic           is_query, take;
  logic [EvW-1:0] want;

  always_comb begin
    is_query = 1'b1;
    take     = 1'b1;
    want     = EV_NONE;
    unique case (in_item_i.opcode)
      OP_PEEK_PRESSED:  begin want = EV_PRESSED;       take = 1'b0; end
      OP_TAKE_PRESSED:  begin want = EV_PRESSED;                    end
      OP_TAKE_HOLD:     begin want = EV_HOLD;                       end
      OP_PEEK_RELEASED: begin want = EV_RELEASED;      take = 1'b0; end
      OP_TAKE_RELEASED: begin want = EV_RELEASED;                   end
      OP_TAKE_HOLD_REL: begin want = EV_HOLD_RELEASED;              end
      default:          begin is_query = 1'b0;        take = 1'b0; end
    endcase
  end

  // Debounce: a button is down only when all its reads are low; missing reads count as up
  logic [BUTTONS-1:0] btn_down;

  always_comb begin
    for (int b = 0; b < BUTTONS; b++) begin
      btn_down[b] = 1'b1;
      for (int r = 0; r < READS; r++) begin
        if (b * READS + r >= RawW) begin
          btn_down[b] = 1'b0;
        end else if (in_item_i.raw_reads[b * READS + r]) begin
          btn_down[b] = 1'b0;
        end
      end
    end
  end

  // Button trackers
  logic [BUTTONS-1:0] query_hit;
  logic [BUTTONS-1:0] down_d;
  logic [EvW-1:0]     pend_q [BUTTONS];
  logic [EvW-1:0]     pend_d [BUTTONS];
  logic [CntW-1:0]    hold_d [BUTTONS];
  logic [CodesW-1:0]  codes;
  logic [MaskW-1:0]   mask;

  for (genvar b = 0; b < BUTTONS; b++) begin : g_btn
    btn_ctl_t ctl;

    assign query_hit[b] = in_acc && is_query
                          && (in_item_i.button_index == IdxW'(b))
                          && (pend_q[b] == want);
    assign ctl.tick = is_tick;
    assign ctl.down = btn_down[b];
    assign ctl.clr  = query_hit[b] && take;

    bphd_button u_button (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .hold_ticks_i (hold_ticks_q),
      .pend_q_o     (pend_q[b]),
      .down_d_o     (down_d[b]),
      .hold_d_o     (hold_d[b]),
      .pend_d_o     (pend_d[b])
    );
  end

  // Report only the first four buttons
  for (genvar b = 0; b < MaskW; b++) begin : g_pack
    if (b < BUTTONS) begin : g_on
      assign mask[b]          = down_d[b];
      assign codes[3*b +: 3]  = pend_d[b];
    end else begin : g_off
      assign mask[b]          = 1'b0;
      assign codes[3*b +: 3]  = EV_NONE;
    end
  end

  // Hold count of button one after the update, zero with a single button
  logic [CntW-1:0] hold1;

  if (BUTTONS > 1) begin : g_h1
    assign hold1 = hold_d[1];
  end else begin : g_h1_none
    assign hold1 = '0;
  end

  // Battery decision on button zero's long hold
  logic long_hold, ap_sel, shutdown_q, shutdown_d, ap_req;

  assign long_hold  = is_tick && battery_mode_q && (hold_d[0] >= shutdown_ticks_q);
  assign ap_sel     = hold1 >= ap_mode_ticks_q;
  assign ap_req     = long_hold && ap_sel;
  assign shutdown_d = shutdown_q
                      || (long_hold && !ap_sel && !in_item_i.external_power);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shutdown_q <= 1'b0;
    end else begin
      shutdown_q <= shutdown_d;
    end
  end

  // Result register
  out_item_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_q.query_true       <= |query_hit;
      out_q.pressed_mask     <= mask;
      out_q.event_codes      <= codes;
      out_q.wake_scan        <= is_tick && down_d[0];
      out_q.shutdown_request <= shutdown_d;
      out_q.ap_mode_request  <= ap_req;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Checks
  a_latch_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(shutdown_q))
    else $error("shutdown latch cleared");

  a_acc_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_q)
    else $error("accepted item produced no result");

  a_wake_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.wake_scan) |-> out_q.pressed_mask[0])
    else $error("wake without button zero down");

  a_tick_no_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.ap_mode_request) |-> !out_q.query_true)
    else $error("access point pulse on a query");

  // A query leaves the down mask where the previous cycle put it
  a_query_keeps_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !is_tick && $past(rst_ni)) |-> (mask == $past(mask)))
    else $error("query changed down mask");

endmodule
